// ----- hw/rtl/assert_macros.svh -----
// assert_macros.svh: assertion helpers for the list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg
// Opcodes and status codes of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	typedef enum logic [3:0] {
		OP_INS_FRONT = 4'd0,
		OP_INS_BACK  = 4'd1,
		OP_REM_FRONT = 4'd2,
		OP_REM_BACK  = 4'd3,
		OP_REM_ALL   = 4'd4,
		OP_SEARCH    = 4'd5,
		OP_REM_AT    = 4'd6,
		OP_READ_AT   = 4'd7,
		OP_LENGTH    = 4'd8,
		OP_CLEAR     = 4'd9
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_EMPTY        = 3'd1,
		ST_NOT_FOUND    = 3'd2,
		ST_OUT_OF_RANGE = 3'd3,
		ST_FULL         = 3'd4
	} status_t;

	// Memory access request from sequencer to store
	typedef struct packed {
		logic        rd_en;
		logic        wr_en;
		logic [31:0] wr_data;
	} mem_ctl_t;

endpackage

// ----- hw/rtl/ole_store.sv -----
// ----------------------------------------------------------------------------
// ole_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ole_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                 clk,
	input  ole_pkg::mem_ctl_t    ctl,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        wr_addr,
	output logic [31:0]          rd_data
);

	logic [31:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/ordered_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values held in one synchronous memory.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// command   in         start & !busy           opcode, value, index
// result    out        done strobe, 1 cycle    result_value, position_or_count,
//                                              status, length
//
// Per command: length, clear, insert back, remove back and errors go straight
// to the finish state; search and remove-all walk the list through the single
// read port, one entry per cycle; remove and read at an index walk from that
// entry to the end or read one entry; insert front shifts every entry, a read
// and then a write per entry. busy stays high until the result is issued, so a
// new command is taken only after the last one is through.
// Reset clears the count, the sequencer and the result outputs; the memory needs no clearing.
// The receiver cannot stall: done is high for one cycle with the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] value,
	input  logic [7:0]         index,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [6:0]         position_or_count,
	output logic [2:0]         status,
	output logic [6:0]         length
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1) + 1;
	localparam int IW = (CW > 8) ? CW : 8;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_FINISH
	} state_t;

	state_t             state_q;
	ole_pkg::opcode_t   op_q;
	logic [31:0]        val_q;
	logic [CW-1:0]      cnt_q;   // element count
	logic [CW-1:0]      rp_q;    // read pointer
	logic [CW-1:0]      wp_q;    // write pointer / shift pointer
	logic [CW-1:0]      stop_q;  // scan end
	logic [CW-1:0]      pc_q;
	logic               pend_q;  // a scan read issued last cycle
	logic [CW-1:0]      pend_pos_q;
	logic [31:0]        res_q;
	logic [2:0]         st_q;

	ole_pkg::mem_ctl_t  ctl;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [31:0]        rd_data;

	ole_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.rd_data (rd_data)
	);

	logic [CW-1:0] idx_w;
	logic          idx_bad;
	logic          scan_issue;

	assign idx_w   = CW'(index);
	assign idx_bad = (index == 8'd0) || (IW'(index) > IW'(cnt_q));
	assign busy    = (state_q != S_IDLE);
	assign scan_issue = (state_q == S_SCAN) && (rp_q < stop_q);

	// Memory port control
	always_comb begin
		ctl      = '0;
		rd_addr  = rp_q[AW-1:0];
		wr_addr  = wp_q[AW-1:0];
		ctl.wr_data = rd_data;
		if (state_q == S_IDLE && start) begin
			if (opcode == ole_pkg::OP_INS_BACK && cnt_q < CW'(CAPACITY)) begin
				ctl.wr_en   = 1'b1;
				wr_addr     = cnt_q[AW-1:0];
				ctl.wr_data = value;
			end
		end
		if (scan_issue) begin
			ctl.rd_en = 1'b1;
		end
		if (state_q == S_SCAN && pend_q && op_q != ole_pkg::OP_SEARCH
				&& op_q != ole_pkg::OP_READ_AT) begin
			// compaction write of the entry just read
			if (op_q == ole_pkg::OP_REM_ALL) begin
				ctl.wr_en = (rd_data != val_q);
			end else begin
				ctl.wr_en = (pend_pos_q != pc_q);
			end
		end
		if (state_q == S_SHIFT_RD) begin
			ctl.rd_en = (wp_q != '0);
			rd_addr   = AW'(wp_q - 1'b1);
		end
		if (state_q == S_SHIFT_WR) begin
			ctl.wr_en = 1'b1;
		end
		if (state_q == S_FINISH && op_q == ole_pkg::OP_INS_FRONT
				&& st_q == ole_pkg::ST_OK) begin
			ctl.wr_en   = 1'b1;
			wr_addr     = '0;
			ctl.wr_data = val_q;
		end
		if (state_q == S_IDLE && start && (opcode == ole_pkg::OP_REM_BACK)) begin
			ctl.rd_en = 1'b1;
			rd_addr   = AW'(cnt_q - 1'b1);
		end
	end

	// Sequencer state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			cnt_q             <= '0;
			pend_q            <= 1'b0;
			done              <= 1'b0;
			op_q              <= ole_pkg::OP_INS_FRONT;
			val_q             <= '0;
			rp_q              <= '0;
			wp_q              <= '0;
			stop_q            <= '0;
			pc_q              <= '0;
			pend_pos_q        <= '0;
			res_q             <= '0;
			st_q              <= ole_pkg::ST_OK;
			result_value      <= '0;
			position_or_count <= '0;
			status            <= '0;
			length            <= '0;
		end else begin
			done   <= 1'b0;
			pend_q <= scan_issue;
			pend_pos_q <= rp_q;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= ole_pkg::opcode_t'(opcode);
						val_q <= value;
						res_q <= '0;
						pc_q  <= '0;
						st_q  <= ole_pkg::ST_OK;
						rp_q  <= '0;
						wp_q  <= '0;
						stop_q <= cnt_q;
						state_q <= S_FINISH;
						case (opcode)
							ole_pkg::OP_INS_FRONT: begin
								if (cnt_q >= CW'(CAPACITY)) st_q <= ole_pkg::ST_FULL;
								else begin
									wp_q    <= cnt_q;
									state_q <= S_SHIFT_RD;
								end
							end
							ole_pkg::OP_INS_BACK: begin
								if (cnt_q >= CW'(CAPACITY)) st_q <= ole_pkg::ST_FULL;
								else cnt_q <= cnt_q + 1'b1;
							end
							ole_pkg::OP_REM_FRONT: begin
								if (cnt_q == '0) st_q <= ole_pkg::ST_EMPTY;
								else begin
									pc_q <= '0;
									op_q <= ole_pkg::OP_REM_AT;
									state_q <= S_SCAN;
								end
							end
							ole_pkg::OP_REM_BACK: begin
								if (cnt_q == '0) st_q <= ole_pkg::ST_EMPTY;
								else begin
									cnt_q <= cnt_q - 1'b1;
									pc_q  <= '1;  // marks read-back pending
								end
							end
							ole_pkg::OP_REM_ALL, ole_pkg::OP_SEARCH: begin
								if (opcode == ole_pkg::OP_SEARCH)
									st_q <= ole_pkg::ST_NOT_FOUND;
								state_q <= S_SCAN;
							end
							ole_pkg::OP_REM_AT, ole_pkg::OP_READ_AT: begin
								if (idx_bad) st_q <= ole_pkg::ST_OUT_OF_RANGE;
								else begin
									pc_q <= idx_w - 1'b1;
									if (opcode == ole_pkg::OP_READ_AT) begin
										rp_q   <= idx_w - 1'b1;
										stop_q <= idx_w;
									end else begin
										rp_q <= idx_w - 1'b1;
										wp_q <= idx_w - 1'b1;
									end
									state_q <= S_SCAN;
								end
							end
							ole_pkg::OP_LENGTH: ;
							ole_pkg::OP_CLEAR: cnt_q <= '0;
							default: st_q <= ole_pkg::ST_OUT_OF_RANGE;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_issue) rp_q <= rp_q + 1'b1;
					if (pend_q) begin
						unique case (op_q)
							ole_pkg::OP_SEARCH: begin
								if (rd_data == val_q && st_q != ole_pkg::ST_OK) begin
									st_q <= ole_pkg::ST_OK;
									pc_q <= pend_pos_q + 1'b1;
								end
							end
							ole_pkg::OP_REM_ALL: begin
								if (rd_data == val_q) pc_q <= pc_q + 1'b1;
								else wp_q <= wp_q + 1'b1;
							end
							ole_pkg::OP_READ_AT: res_q <= rd_data;
							default: begin
								if (pend_pos_q == pc_q) res_q <= rd_data;
								else wp_q <= wp_q + 1'b1;
							end
						endcase
					end
					if (!scan_issue && !pend_q) begin
						if (op_q == ole_pkg::OP_REM_ALL) cnt_q <= wp_q;
						if (op_q == ole_pkg::OP_REM_AT) begin
							cnt_q <= cnt_q - 1'b1;
							pc_q  <= '0;
						end
						if (op_q == ole_pkg::OP_READ_AT) pc_q <= '0;
						state_q <= S_FINISH;
					end
				end
				S_SHIFT_RD: begin
					if (wp_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_FINISH;
					end else state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					wp_q    <= wp_q - 1'b1;
					state_q <= S_SHIFT_RD;
				end
				S_FINISH: begin
					done              <= 1'b1;
					result_value      <= (op_q == ole_pkg::OP_REM_BACK && pc_q != '0)
						? rd_data : res_q;
					position_or_count <= (op_q == ole_pkg::OP_REM_BACK) ? 7'd0 : 7'(pc_q);
					status            <= st_q;
					length            <= 7'(cnt_q);
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`ASSERT_NEXT(a_done_once, clk, arst_n, done, !done)
	`ASSERT_IMPL(a_busy_done, clk, arst_n, done, !busy)

endmodule

// ----- bench/tb_ordered_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Drives list commands through the start/busy handshake, mirrors the list
// contents in a queue to predict each result, and compares every done strobe
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;

	localparam int CAP = 64;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] val;
		logic [7:0]  idx;
	} cmd_t;

	typedef struct {
		logic [31:0] res;
		logic [6:0]  pc;
		logic [2:0]  st;
		logic [6:0]  len;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0] opcode = '0;
	logic signed [31:0] value = '0;
	logic [7:0] index = '0;
	logic done;
	logic signed [31:0] result_value;
	logic [6:0] position_or_count;
	logic [2:0] status;
	logic [6:0] length;

	cmd_t pending_cmds[$];
	reply_t expected_replies[$];
	logic [31:0] list_mirror[$];
	logic [31:0] value_pool[$];
	int error_count = 0;
	int idle_cycles = 0;
	int cycle_no = 0;
	bit stim_done = 1'b0;

	ordered_list_engine #(.CAPACITY(CAP)) DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the reply of one command and update the mirrored list
	function automatic reply_t apply_cmd(cmd_t c);
		reply_t r;
		int n;
		n = list_mirror.size();
		r.res = '0;
		r.pc = '0;
		r.st = ole_pkg::ST_OK;
		case (c.op)
			ole_pkg::OP_INS_FRONT:
				if (n >= CAP) r.st = ole_pkg::ST_FULL; else list_mirror.push_front(c.val);
			ole_pkg::OP_INS_BACK:
				if (n >= CAP) r.st = ole_pkg::ST_FULL; else list_mirror.push_back(c.val);
			ole_pkg::OP_REM_FRONT:
				if (n == 0) r.st = ole_pkg::ST_EMPTY; else r.res = list_mirror.pop_front();
			ole_pkg::OP_REM_BACK:
				if (n == 0) r.st = ole_pkg::ST_EMPTY; else r.res = list_mirror.pop_back();
			ole_pkg::OP_REM_ALL: begin
				for (int k = n - 1; k >= 0; k--)
					if (list_mirror[k] == c.val) begin
						list_mirror.delete(k);
						r.pc++;
					end
			end
			ole_pkg::OP_SEARCH: begin
				r.st = ole_pkg::ST_NOT_FOUND;
				for (int k = 0; k < n; k++)
					if (list_mirror[k] == c.val) begin
						r.pc = 7'(k + 1);
						r.st = ole_pkg::ST_OK;
						break;
					end
			end
			ole_pkg::OP_REM_AT, ole_pkg::OP_READ_AT: begin
				if (c.idx == 0 || c.idx > n) begin
					r.st = ole_pkg::ST_OUT_OF_RANGE;
				end else begin
					r.res = list_mirror[c.idx - 1];
					if (c.op == ole_pkg::OP_REM_AT) list_mirror.delete(c.idx - 1);
				end
			end
			ole_pkg::OP_LENGTH: ;
			ole_pkg::OP_CLEAR: list_mirror.delete();
			default: r.st = ole_pkg::ST_OUT_OF_RANGE;
		endcase
		r.len = 7'(list_mirror.size());
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic add_cmd(logic [3:0] op, logic [31:0] val, logic [7:0] idx);
		cmd_t c;
		c.op = op;
		c.val = val;
		c.idx = idx;
		pending_cmds.push_back(c);
	endtask

	// Pick a value, mostly from a small pool so searches and removals hit
	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 3) == 0 || value_pool.size() == 0) return $urandom();
		return value_pool[$urandom_range(0, value_pool.size() - 1)];
	endfunction

	// Fill the command queue: directed corners first, then random traffic
	initial begin
		int op_sel;
		for (int k = 0; k < 8; k++) value_pool.push_back($urandom());
		value_pool.push_back(32'h8000_0000);
		value_pool.push_back(32'h7FFF_FFFF);
		value_pool.push_back(32'hFFFF_FFFF);
		value_pool.push_back(32'h0);

		add_cmd(ole_pkg::OP_REM_FRONT, 32'd0, 8'd0);
		add_cmd(ole_pkg::OP_REM_BACK, 32'd0, 8'd0);
		add_cmd(ole_pkg::OP_SEARCH, 32'd5, 8'd0);
		add_cmd(ole_pkg::OP_READ_AT, 32'd0, 8'd1);
		add_cmd(ole_pkg::OP_INS_BACK, 32'h8000_0000, 8'd0);
		add_cmd(ole_pkg::OP_INS_FRONT, 32'h7FFF_FFFF, 8'd0);
		add_cmd(ole_pkg::OP_INS_BACK, 32'hFFFF_FFFF, 8'd0);
		add_cmd(ole_pkg::OP_INS_BACK, 32'h7FFF_FFFF, 8'd0);
		add_cmd(ole_pkg::OP_SEARCH, 32'hFFFF_FFFF, 8'd0);
		add_cmd(ole_pkg::OP_READ_AT, 32'd0, 8'd0);
		add_cmd(ole_pkg::OP_READ_AT, 32'd0, 8'hFF);
		add_cmd(ole_pkg::OP_READ_AT, 32'd0, 8'd4);
		add_cmd(ole_pkg::OP_REM_AT, 32'd0, 8'd2);
		add_cmd(ole_pkg::OP_REM_ALL, 32'h7FFF_FFFF, 8'd0);
		add_cmd(ole_pkg::OP_REM_ALL, 32'h1234_5678, 8'd0);
		add_cmd(ole_pkg::OP_LENGTH, 32'd0, 8'd0);
		add_cmd(4'd10, 32'd0, 8'd0);
		add_cmd(4'd15, 32'hFFFF_FFFF, 8'hFF);
		add_cmd(ole_pkg::OP_CLEAR, 32'd0, 8'd0);
		// Fill to capacity and overflow both ends
		for (int k = 0; k < CAP; k++) add_cmd(ole_pkg::OP_INS_BACK, pick_value(), 8'd0);
		add_cmd(ole_pkg::OP_INS_BACK, 32'd1, 8'd0);
		add_cmd(ole_pkg::OP_INS_FRONT, 32'd1, 8'd0);
		add_cmd(ole_pkg::OP_READ_AT, 32'd0, 8'(CAP));
		add_cmd(ole_pkg::OP_REM_AT, 32'd0, 8'(CAP + 1));
		add_cmd(ole_pkg::OP_REM_ALL, value_pool[0], 8'd0);
		add_cmd(ole_pkg::OP_CLEAR, 32'd0, 8'd0);

		// Random part: a weighted mix of all opcodes, undefined ones included
		for (int k = 0; k < 390; k++) begin
			op_sel = $urandom_range(0, 99);
			if (op_sel < 30)
				add_cmd(4'($urandom_range(0, 1)), pick_value(), 8'($urandom()));
			else if (op_sel < 40)
				add_cmd(4'($urandom_range(2, 3)), $urandom(), 8'($urandom()));
			else if (op_sel < 52)
				add_cmd(ole_pkg::OP_REM_ALL, pick_value(), 8'($urandom()));
			else if (op_sel < 66)
				add_cmd(ole_pkg::OP_SEARCH, pick_value(), 8'($urandom()));
			else if (op_sel < 86)
				add_cmd(4'($urandom_range(6, 7)), $urandom(),
					8'(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 40)));
			else if (op_sel < 93)
				add_cmd(ole_pkg::OP_LENGTH, $urandom(), 8'($urandom()));
			else if (op_sel < 95)
				add_cmd(ole_pkg::OP_CLEAR, $urandom(), 8'($urandom()));
			else if (op_sel < 97)
				add_cmd(4'($urandom_range(10, 15)), $urandom(), 8'($urandom()));
			else begin
				// burst of back inserts to push the list toward capacity now and then
				for (int j = 0; j < 20; j++)
					add_cmd(ole_pkg::OP_INS_BACK, pick_value(), 8'd0);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Drive commands; hold start until accepted, idle at random outside a window of back-to-back traffic
	always @(posedge clk) begin
		cmd_t c;
		cycle_no <= cycle_no + 1;
		if (arst_n) begin
			if (start && !busy) begin
				c.op = opcode;
				c.val = value;
				c.idx = index;
				expected_replies.push_back(apply_cmd(c));
			end
			if (!start || !busy) begin
				if (pending_cmds.size() != 0 &&
						(cycle_no > 3000 && cycle_no < 9000 || $urandom_range(0, 99) >= 6)) begin
					c = pending_cmds.pop_front();
					start <= 1'b1;
					opcode <= c.op;
					value <= c.val;
					index <= c.idx;
				end else begin
					start <= 1'b0;
					if (pending_cmds.size() == 0) stim_done <= 1'b1;
				end
			end
		end
	end

	// Compare each reply with the oldest prediction
	always @(posedge clk) begin
		reply_t e;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("unexpected reply", 32'(status), 32'd0);
			end else begin
				e = expected_replies.pop_front();
				if (result_value !== e.res) report_mismatch("result_value", result_value, e.res);
				if (position_or_count !== e.pc)
					report_mismatch("position_or_count", 32'(position_or_count), 32'(e.pc));
				if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
				if (length !== e.len) report_mismatch("length", 32'(length), 32'(e.len));
			end
		end
	end

	// Watchdog: count cycles with nothing accepted and no reply
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_replies.size() == 0 && !start);
		wait (expected_replies.size() == 0);
		repeat (2 * CAP + 20) @(posedge clk);
		if (error_count == 0 && expected_replies.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
